FILE: rtl/core/m3i_pkg.sv
// Package for the 3x3 matrix inverse: lane count and cofactor operand table.
// No dependencies.
package m3i_pkg;

  localparam int NUM_LANES = 9;

  typedef logic [3:0] idx_t;

  // Cofactor k is a[X0]*a[X1] - a[Y0]*a[Y1].
  localparam idx_t COF_IDX [NUM_LANES][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

FILE: rtl/core/m3i_in_if.sv
// Input channel of the matrix inverse: valid/ready handshake and nine entries.
// No dependencies.
interface m3i_in_if #(parameter int WORD_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [WORD_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

FILE: rtl/core/m3i_out_if.sv
// Output channel of the matrix inverse: valid/ready handshake, inverse,
// determinant and singular flag. No dependencies.
interface m3i_out_if #(parameter int WORD_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [WORD_WIDTH-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
  logic signed [WORD_WIDTH-1:0] determinant;
  logic singular;
  modport source(output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                 determinant, singular, input ready);
  modport sink(input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
               determinant, singular, output ready);
endinterface

FILE: rtl/core/m3i_cof.sv
// One cofactor lane: two registered products, then their registered difference.
// No dependencies.
module m3i_cof #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [WORD_WIDTH-1:0]  x0,
  input  logic signed [WORD_WIDTH-1:0]  x1,
  input  logic signed [WORD_WIDTH-1:0]  y0,
  input  logic signed [WORD_WIDTH-1:0]  y1,
  output logic signed [2*WORD_WIDTH:0]  c
);
  localparam int PW = 2 * WORD_WIDTH;

  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;

  always_ff @(posedge clk) begin
    if (en) begin
      px <= x0 * x1;
      py <= y0 * y1;
      c  <= (PW+1)'(px) - (PW+1)'(py);
    end
  end
endmodule

FILE: rtl/core/m3i_det.sv
// Determinant merge: expands row 0 against three cofactors, rounds half away
// from zero to the word format and saturates. No dependencies.
module m3i_det #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [WORD_WIDTH-1:0]  a0,
  input  logic signed [WORD_WIDTH-1:0]  a1,
  input  logic signed [WORD_WIDTH-1:0]  a2,
  input  logic signed [2*WORD_WIDTH:0]  c0,
  input  logic signed [2*WORD_WIDTH:0]  c3,
  input  logic signed [2*WORD_WIDTH:0]  c6,
  output logic signed [WORD_WIDTH-1:0]  d
);
  localparam int W  = WORD_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int PW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam logic [DW:0] HALF  = (DW+1)'(1) << (2 * FRAC_BITS - 1);
  localparam logic [DW:0] LIM_P = (DW+1)'(1) << (W - 1);
  localparam logic [DW:0] LIM_M = LIM_P - (DW+1)'(1);

  logic signed [W-1:0]  ad [2][3];
  logic signed [PW-1:0] pl [3];
  logic signed [PW-1:0] ph [3];
  logic signed [DW-1:0] dsum;
  logic [DW-1:0]        mag;
  logic                 neg;
  logic [DW:0]          rnd;
  logic signed [W-1:0]  d_next;
  logic signed [W-1:0]  av [3];
  logic signed [CW-1:0] cv [3];

  assign av[0] = ad[1][0];
  assign av[1] = ad[1][1];
  assign av[2] = ad[1][2];
  assign cv[0] = c0;
  assign cv[1] = c3;
  assign cv[2] = c6;

  always_ff @(posedge clk) begin
    if (en) begin
      ad[0][0] <= a0;
      ad[0][1] <= a1;
      ad[0][2] <= a2;
      ad[1]    <= ad[0];
      for (int j = 0; j < 3; j++) begin
        pl[j] <= av[j] * $signed({1'b0, cv[j][W-1:0]});
        ph[j] <= av[j] * $signed(cv[j][CW-1:W]);
      end
      dsum <= (DW'(ph[0]) <<< W) + DW'(pl[0]) + (DW'(ph[1]) <<< W) + DW'(pl[1])
            + (DW'(ph[2]) <<< W) + DW'(pl[2]);
      neg  <= dsum[DW-1];
      mag  <= dsum[DW-1] ? DW'(-dsum) : DW'(dsum);
      d    <= d_next;
    end
  end

  always_comb begin
    rnd = ((DW+1)'(mag) + HALF) >> (2 * FRAC_BITS);
    if (neg) begin
      d_next = (rnd > LIM_P) ? W'(LIM_P) : W'(-rnd);
    end else begin
      d_next = (rnd > LIM_M) ? W'(LIM_M) : W'(rnd);
    end
  end
endmodule

FILE: rtl/core/m3i_div.sv
// One divide lane: rounded, saturated quotient of a cofactor by the
// determinant, one quotient bit per pipeline stage. No dependencies.
module m3i_div #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [2*WORD_WIDTH:0]  c,
  input  logic signed [WORD_WIDTH-1:0]  d,
  input  logic                          zero,
  output logic signed [WORD_WIDTH-1:0]  b
);
  localparam int W  = WORD_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int NW = CW + 1;
  localparam int RW = 2 * W;
  localparam logic [W-1:0] LIM_P = W'(1) << (W - 1);
  localparam logic [W-1:0] LIM_M = LIM_P - W'(1);

  logic [CW-1:0] cmag;
  logic [W-1:0]  dmag;
  logic [NW-1:0] num;
  logic [W:0]    den_in;

  logic [RW-1:0] rem   [W+1];
  logic [W-1:0]  q     [W+1];
  logic [W:0]    den   [W+1];
  logic          big   [W+1];
  logic          neg   [W+1];
  logic          zr    [W+1];
  logic signed [W-1:0] b_next;

  always_comb begin
    cmag   = c[CW-1] ? CW'(-c) : CW'(c);
    dmag   = d[W-1] ? W'(-d) : W'(d);
    num    = {cmag, 1'b0} + NW'(dmag);
    den_in = {dmag, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num[RW-1:0];
      q[0]   <= '0;
      den[0] <= den_in;
      big[0] <= num >= (NW'(den_in) << W);
      neg[0] <= c[CW-1] ^ d[W-1];
      zr[0]  <= zero;
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int BIT = W - 1 - s;
    logic [RW:0] dsh;
    logic        ge;
    assign dsh = (RW+1)'(den[s]) << BIT;
    assign ge  = {1'b0, rem[s]} >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? rem[s] - dsh[RW-1:0] : rem[s];
        q[s+1]   <= q[s] | (W'(ge) << BIT);
        den[s+1] <= den[s];
        big[s+1] <= big[s];
        neg[s+1] <= neg[s];
        zr[s+1]  <= zr[s];
      end
    end
  end

  always_comb begin
    if (zr[W]) begin
      b_next = '0;
    end else if (neg[W]) begin
      b_next = (big[W] || q[W] > LIM_P) ? LIM_P : W'(-q[W]);
    end else begin
      b_next = (big[W] || q[W] > LIM_M) ? LIM_M : q[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b <= b_next;
    end
  end
endmodule

FILE: rtl/core/matrix3x3_inverse.sv
// 3x3 matrix inverse by adjugate in signed fixed point, nine parallel lanes.
// Path from input transfer to result: input register, cofactor lanes, determinant merge, divide lanes.
// Throughput: one matrix per cycle; the whole pipeline advances together and
// halts only while a finished result waits at the output register.
// Reset: rst, synchronous, clears the valid flags of every stage.
// Depends on m3i_pkg, m3i_in_if, m3i_out_if, m3i_cof, m3i_det, m3i_div.
module matrix3x3_inverse #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic clk,
  input logic rst,
  m3i_in_if.sink    req,
  m3i_out_if.source rsp
);
  import m3i_pkg::*;

  localparam int W       = WORD_WIDTH;
  localparam int CW      = 2 * W + 1;
  localparam int COF_LAT = 2;
  localparam int DET_LAT = 4;
  localparam int DIV_LAT = W + 2;
  localparam int N       = 1 + COF_LAT + DET_LAT + DIV_LAT;

  logic [N-1:0]         vld;
  logic                 en;
  logic signed [W-1:0]  a   [NUM_LANES];
  logic signed [CW-1:0] c   [NUM_LANES];
  logic signed [CW-1:0] cd  [DET_LAT][NUM_LANES];
  logic signed [W-1:0]  det;
  logic signed [W-1:0]  dd  [DIV_LAT];
  logic signed [W-1:0]  b   [NUM_LANES];
  logic                 zero;

  assign en        = !vld[N-1] || rsp.ready;
  assign req.ready = en && !rst;
  assign zero      = det == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a[0] <= req.a00;
      a[1] <= req.a01;
      a[2] <= req.a02;
      a[3] <= req.a10;
      a[4] <= req.a11;
      a[5] <= req.a12;
      a[6] <= req.a20;
      a[7] <= req.a21;
      a[8] <= req.a22;
      cd[0] <= c;
      for (int s = 1; s < DET_LAT; s++) cd[s] <= cd[s-1];
      dd[0] <= det;
      for (int s = 1; s < DIV_LAT; s++) dd[s] <= dd[s-1];
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_cof
    m3i_cof #(.WORD_WIDTH(W)) u_cof (
      .clk (clk),
      .en  (en),
      .x0  (a[COF_IDX[k][0]]),
      .x1  (a[COF_IDX[k][1]]),
      .y0  (a[COF_IDX[k][2]]),
      .y1  (a[COF_IDX[k][3]]),
      .c   (c[k])
    );
  end

  m3i_det #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_det (
    .clk (clk),
    .en  (en),
    .a0  (a[0]),
    .a1  (a[1]),
    .a2  (a[2]),
    .c0  (c[0]),
    .c3  (c[3]),
    .c6  (c[6]),
    .d   (det)
  );

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_div
    m3i_div #(.WORD_WIDTH(W)) u_div (
      .clk  (clk),
      .en   (en),
      .c    (cd[DET_LAT-1][k]),
      .d    (det),
      .zero (zero),
      .b    (b[k])
    );
  end

  assign rsp.valid       = vld[N-1];
  assign rsp.b00         = b[0];
  assign rsp.b01         = b[1];
  assign rsp.b02         = b[2];
  assign rsp.b10         = b[3];
  assign rsp.b11         = b[4];
  assign rsp.b12         = b[5];
  assign rsp.b20         = b[6];
  assign rsp.b21         = b[7];
  assign rsp.b22         = b[8];
  assign rsp.determinant = dd[DIV_LAT-1];
  assign rsp.singular    = dd[DIV_LAT-1] == '0;
endmodule

FILE: bench/matrix3x3_inverse_tb.sv
// Testbench for matrix3x3_inverse: drives 3x3 Q16.16 matrices and checks the inverse,
// determinant and singular flag against an exact wide-integer prediction.
// Depends on m3i_pkg, m3i_in_if, m3i_out_if and the matrix3x3_inverse RTL.
module matrix3x3_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1850;
  localparam logic [W-1:0] ONE = 32'h0001_0000;
  localparam logic [W-1:0] WMAX = 32'h7FFF_FFFF;
  localparam logic [W-1:0] WMIN = 32'h8000_0000;

  typedef logic [8:0][W-1:0] matrix_t;
  typedef struct packed {
    logic [8:0][W-1:0] inv;
    logic [W-1:0] det;
    logic sing;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  m3i_in_if #(.WORD_WIDTH(W)) req_if();
  m3i_out_if #(.WORD_WIDTH(W)) rsp_if();

  matrix3x3_inverse #(.WORD_WIDTH(W), .FRAC_BITS(16)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #1 clk = ~clk;

  matrix_t matrix_q[$];
  inverse_t inverse_q[$];
  matrix_t cur_matrix;
  int errors = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  int in_sent = 0;
  int out_seen = 0;

  function automatic logic [W-1:0] saturate(logic signed [127:0] x);
    if (x > $signed(128'sh7FFF_FFFF)) return WMAX;
    if (x < -$signed(128'sh8000_0000)) return WMIN;
    return x[W-1:0];
  endfunction

  function automatic inverse_t predict_inverse(matrix_t m);
    logic signed [127:0] a[9];
    logic signed [127:0] cof[9];
    logic signed [127:0] full_det;
    logic signed [127:0] rdet;
    logic [127:0] mag;
    logic [127:0] dmag;
    logic [127:0] quo;
    inverse_t r;
    for (int i = 0; i < 9; i++) a[i] = $signed(m[i]);
    cof[0] = a[4] * a[8] - a[5] * a[7];
    cof[1] = a[2] * a[7] - a[1] * a[8];
    cof[2] = a[1] * a[5] - a[2] * a[4];
    cof[3] = a[5] * a[6] - a[3] * a[8];
    cof[4] = a[0] * a[8] - a[2] * a[6];
    cof[5] = a[2] * a[3] - a[0] * a[5];
    cof[6] = a[3] * a[7] - a[4] * a[6];
    cof[7] = a[1] * a[6] - a[0] * a[7];
    cof[8] = a[0] * a[4] - a[1] * a[3];
    full_det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    mag = full_det < 0 ? -full_det : full_det;
    mag = (mag + (128'd1 << 31)) >> 32;
    rdet = full_det < 0 ? -$signed(mag) : $signed(mag);
    r.det = saturate(rdet);
    r.sing = (r.det == '0);
    for (int i = 0; i < 9; i++) begin
      if (r.sing) begin
        r.inv[i] = '0;
      end else begin
        rdet = $signed(r.det);
        dmag = rdet < 0 ? -rdet : rdet;
        mag = cof[i] < 0 ? -cof[i] : cof[i];
        quo = (2 * mag + dmag) / (2 * dmag);
        r.inv[i] = saturate(((cof[i] < 0) != (rdet < 0)) ? -$signed(quo) : $signed(quo));
      end
    end
    return r;
  endfunction

  function automatic logic [W-1:0] rand_entry(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      2: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      default: return ($urandom_range(0, 1) ? WMAX : WMIN) ^ $urandom_range(0, 3);
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    int k0;
    int k1;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) m[i] = rand_entry(kind < 2 ? 0 : (kind < 6 ? 1 : 2));
    if (kind == 9) begin
      for (int i = 0; i < 9; i++) m[i] = rand_entry($urandom_range(0, 3));
    end else if (kind >= 7) begin
      k0 = $signed($urandom_range(0, 6)) - 3;
      k1 = $signed($urandom_range(0, 6)) - 3;
      for (int c = 0; c < 3; c++) begin
        m[6 + c] = k0 * $signed(m[c]) + k1 * $signed(m[3 + c]);
        if (kind == 8) m[6 + c] = m[6 + c] + $signed($urandom_range(0, 4)) - 2;
      end
    end
    return m;
  endfunction

  task automatic report_mismatch(string field, logic [W-1:0] got, logic [W-1:0] exp);
    $display("mismatch on result %0d, %s: got %h, expected %h", out_seen, field, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        inverse_q.push_back(predict_inverse(cur_matrix));
        in_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          req_if.valid <= 1'b0;
        end else if (matrix_q.size() > 0) begin
          cur_matrix = matrix_q.pop_front();
          {req_if.a22, req_if.a21, req_if.a20, req_if.a12, req_if.a11, req_if.a10,
           req_if.a02, req_if.a01, req_if.a00} <= cur_matrix;
          req_if.valid <= 1'b1;
          in_gap = ((in_sent / 150) % 3 == 1) ? 0 : $urandom_range(0, 17);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    inverse_t exp_r;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (inverse_q.size() == 0) begin
          report_mismatch("unexpected transfer", rsp_if.determinant, '0);
        end else begin
          exp_r = inverse_q.pop_front();
          if (rsp_if.b00 !== exp_r.inv[0]) report_mismatch("b00", rsp_if.b00, exp_r.inv[0]);
          if (rsp_if.b01 !== exp_r.inv[1]) report_mismatch("b01", rsp_if.b01, exp_r.inv[1]);
          if (rsp_if.b02 !== exp_r.inv[2]) report_mismatch("b02", rsp_if.b02, exp_r.inv[2]);
          if (rsp_if.b10 !== exp_r.inv[3]) report_mismatch("b10", rsp_if.b10, exp_r.inv[3]);
          if (rsp_if.b11 !== exp_r.inv[4]) report_mismatch("b11", rsp_if.b11, exp_r.inv[4]);
          if (rsp_if.b12 !== exp_r.inv[5]) report_mismatch("b12", rsp_if.b12, exp_r.inv[5]);
          if (rsp_if.b20 !== exp_r.inv[6]) report_mismatch("b20", rsp_if.b20, exp_r.inv[6]);
          if (rsp_if.b21 !== exp_r.inv[7]) report_mismatch("b21", rsp_if.b21, exp_r.inv[7]);
          if (rsp_if.b22 !== exp_r.inv[8]) report_mismatch("b22", rsp_if.b22, exp_r.inv[8]);
          if (rsp_if.determinant !== exp_r.det)
            report_mismatch("determinant", rsp_if.determinant, exp_r.det);
          if (rsp_if.singular !== exp_r.sing)
            report_mismatch("singular", W'(rsp_if.singular), W'(exp_r.sing));
        end
        out_seen++;
        out_gap = ((out_seen / 200) % 3 == 2) ? 0 : $urandom_range(0, 17);
      end
      if (out_gap > 0) begin
        out_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** matrix3x3_inverse: FAILED **");
      $finish;
    end
  end

  initial begin
    matrix_t m;
    int total_items;
    req_if.valid = 1'b0;
    {req_if.a22, req_if.a21, req_if.a20, req_if.a12, req_if.a11, req_if.a10,
     req_if.a02, req_if.a01, req_if.a00} = '0;
    rsp_if.ready = 1'b0;

    m = '0; m[0] = ONE; m[4] = ONE; m[8] = ONE; matrix_q.push_back(m);
    matrix_q.push_back('0);
    matrix_q.push_back({9{WMAX}});
    matrix_q.push_back({9{WMIN}});
    m = '0; m[0] = WMAX; m[4] = WMAX; m[8] = WMAX; matrix_q.push_back(m);
    m = '0; m[0] = WMIN; m[4] = WMIN; m[8] = WMIN; matrix_q.push_back(m);
    m = '0; m[0] = WMIN; m[4] = WMAX; m[8] = WMIN; matrix_q.push_back(m);
    m = '0; m[0] = 2 * ONE; m[4] = -4 * ONE; m[8] = ONE / 2; matrix_q.push_back(m);
    m = '0; m[0] = 3 * ONE; m[4] = 3 * ONE; m[8] = 3 * ONE; matrix_q.push_back(m);
    m = '0; m[0] = 1; m[4] = 1; m[8] = 1; matrix_q.push_back(m);
    m = '0; m[0] = 32'd256; m[4] = 32'd256; m[8] = 32'd256; matrix_q.push_back(m);
    m = '0; m[0] = 32'h0000_8000; m[4] = 32'h0000_8000; m[8] = 32'h0000_8000;
    matrix_q.push_back(m);
    m = '0; m[0] = 32'h0100_0000; m[4] = 32'h0100_0000; m[8] = 1; matrix_q.push_back(m);
    m = '0; m[1] = ONE; m[3] = ONE; m[8] = -ONE; matrix_q.push_back(m);
    for (int i = 0; i < 9; i++) m[i] = (i + 1) * ONE;
    matrix_q.push_back(m);
    m = '0; m[2] = 5 * ONE; m[4] = -ONE; m[6] = 7 * ONE; m[0] = 32'h0000_0001;
    matrix_q.push_back(m);
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? WMAX : WMIN;
    matrix_q.push_back(m);
    m = '0; m[0] = 32'h00FF_FFFF; m[4] = WMIN; m[8] = 32'hFFFF_FFFF; matrix_q.push_back(m);
    for (int i = 0; i < 9; i++) m[i] = (i == 0 || i == 4 || i == 8) ? 4 * ONE : ONE;
    matrix_q.push_back(m);
    for (int i = 0; i < RANDOM_ITEMS; i++) matrix_q.push_back(random_matrix());
    total_items = matrix_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (out_seen >= total_items);
    repeat (100) @(posedge clk);
    if (errors == 0 && inverse_q.size() == 0) begin
      $display("** matrix3x3_inverse: PASSED **");
    end else begin
      $display("** matrix3x3_inverse: FAILED **");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/m3i_pkg.sv
rtl/core/m3i_in_if.sv
rtl/core/m3i_out_if.sv
rtl/core/m3i_cof.sv
rtl/core/m3i_det.sv
rtl/core/m3i_div.sv
rtl/core/matrix3x3_inverse.sv
bench/matrix3x3_inverse_tb.sv
